>>> rtl/message_buffer_pool_queue_assert.svh
// assertion macros for the buffer pool queue
// expects signals named clk and rst in the scope of each use
`ifndef MESSAGE_BUFFER_POOL_QUEUE_ASSERT_SVH
`define MESSAGE_BUFFER_POOL_QUEUE_ASSERT_SVH

// plain condition checked at every clock edge outside reset
`define MBPQ_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// implication checked at every clock edge outside reset
`define MBPQ_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbpq_pkg.sv
// shared types, codes and sizes of the buffer pool queue
// no dependencies
`timescale 1ns / 1ps

package mbpq_pkg;

  // store size and field widths
  localparam int NUM_BUFS       = 64;
  localparam int IDX_W          = $clog2(NUM_BUFS);
  localparam int CNT_W          = 7;
  localparam int STAT_W         = 32;
  localparam int STATUS_W       = 2;
  localparam int OP_W           = 3;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int GROWTH_DIVISOR = 2;

  // register values after reset
  localparam logic [CNT_W-1:0] RESET_POOL_SIZE    = 7'd32;
  localparam logic             RESET_ALLOW_GROWTH = 1'b1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_NW = 3'd1;
  localparam logic [OP_W-1:0] OP_SEND     = 3'd2;
  localparam logic [OP_W-1:0] OP_RECV     = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd4;
  localparam logic [OP_W-1:0] OP_PURGE    = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_POOL_SIZE = 3'd0;

  // where a buffer currently lives
  typedef enum logic [1:0] {
    MARK_UNUSED = 2'd0,
    MARK_FREE   = 2'd1,
    MARK_READY  = 2'd2,
    MARK_HELD   = 2'd3
  } mark_t;

  // one entry of the link memory
  typedef struct packed {
    mark_t            mark;
    logic [IDX_W-1:0] link;
  } entry_t;

  // configuration seen by the controller
  typedef struct packed {
    logic             reinit;
    logic [CNT_W-1:0] init_n;
    logic             grow_en;
  } cfg_t;

endpackage

>>> rtl/mbpq_cfg.sv
// apb configuration registers of the buffer pool queue
// depends on mbpq_pkg
`timescale 1ns / 1ps

module mbpq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbpq_pkg::ADDR_W-1:0]   paddr,
  input  logic [mbpq_pkg::DATA_W-1:0]   pwdata,
  output logic [mbpq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mbpq_pkg::cfg_t                cfg
);

  logic [mbpq_pkg::CNT_W-1:0] pool_size;
  logic                       allow_growth;
  logic                       wr_xfer;
  logic                       sel_grow;
  logic [mbpq_pkg::CNT_W-1:0] size_after;

  // pool size limited to one up to the store size
  function automatic logic [mbpq_pkg::CNT_W-1:0] clamp_size(
    input logic [mbpq_pkg::CNT_W-1:0] v
  );
    logic [mbpq_pkg::CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = mbpq_pkg::CNT_W'(1);
    end else if (v > mbpq_pkg::CNT_W'(mbpq_pkg::NUM_BUFS)) begin
      r = mbpq_pkg::CNT_W'(mbpq_pkg::NUM_BUFS);
    end
    return r;
  endfunction

  // write transfer decode, word select on bit two
  assign wr_xfer  = psel && penable && pwrite;
  assign sel_grow = paddr[2];
  assign pready   = 1'b1;

  // register storage
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size    <= mbpq_pkg::RESET_POOL_SIZE;
      allow_growth <= mbpq_pkg::RESET_ALLOW_GROWTH;
    end else if (wr_xfer) begin
      if (sel_grow) begin
        allow_growth <= pwdata[0];
      end else begin
        pool_size <= pwdata[mbpq_pkg::CNT_W-1:0];
      end
    end
  end

  // pool size that the reinit starts from
  assign size_after = (wr_xfer && !sel_grow) ? pwdata[mbpq_pkg::CNT_W-1:0] : pool_size;

  assign cfg.reinit  = wr_xfer;
  assign cfg.init_n  = clamp_size(size_after);
  assign cfg.grow_en = allow_growth;

  // read data, zero on unaligned addresses
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == mbpq_pkg::ADDR_POOL_SIZE[1:0]) begin
      if (sel_grow) begin
        prdata = mbpq_pkg::DATA_W'(allow_growth);
      end else begin
        prdata = mbpq_pkg::DATA_W'(pool_size);
      end
    end
  end

endmodule

>>> rtl/mbpq_store.sv
// link and mark memory of the buffer pool queue, one read and one write port
// depends on mbpq_pkg
`timescale 1ns / 1ps

module mbpq_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        rd_en,
  input  logic [mbpq_pkg::IDX_W-1:0]  rd_addr,
  input  logic                        wr_en,
  input  logic [mbpq_pkg::IDX_W-1:0]  wr_addr,
  input  mbpq_pkg::entry_t            wr_entry,
  input  logic [mbpq_pkg::CNT_W-1:0]  pool_level,
  output mbpq_pkg::entry_t            rd_entry
);

  mbpq_pkg::entry_t             mem [mbpq_pkg::NUM_BUFS];
  mbpq_pkg::entry_t             rd_q;
  mbpq_pkg::entry_t             dflt;
  logic [mbpq_pkg::IDX_W-1:0]   rd_addr_q;
  logic [mbpq_pkg::NUM_BUFS-1:0] touched;

  // memory array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // one written flag per entry, cleared on reset and reinit
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      touched <= '0;
    end else if (wr_en) begin
      touched[wr_addr] <= 1'b1;
    end
  end

  // unwritten entries read as freshly chained pool entries
  always_comb begin
    dflt.mark = (mbpq_pkg::CNT_W'(rd_addr_q) < pool_level) ? mbpq_pkg::MARK_FREE
                                                          : mbpq_pkg::MARK_UNUSED;
    dflt.link = (rd_addr_q == '0) ? '0 : rd_addr_q - 1'b1;
  end

  assign rd_entry = touched[rd_addr_q] ? rd_q : dflt;

endmodule

>>> rtl/message_buffer_pool_queue.sv
// buffer pool queue top level: operation sequencer over the link memory
// depends on mbpq_pkg, mbpq_cfg, mbpq_store and the assertion header
//
//  channel   transfer when                         payload
//  command   start && !busy                        op, buf_index
//  result    done (one cycle, no backpressure)     status .. waits_total
//  config    psel && penable && pwrite (pready=1)  paddr, pwdata / prdata
//
// a command passes through the exec state before the next transfer can be taken
// send onto a non-empty ready queue also passes through the link state (two link memory writes)
// purge moves k ready buffers onto the free list, one entry per cycle
// the rate is set by the registered read, then the write, of the link memory
// rst clears everything at once (pool size 32, growth on), no clearing pass
// results cannot be stalled; counts on the result ports hold until the next op
`timescale 1ns / 1ps
`include "message_buffer_pool_queue_assert.svh"

module message_buffer_pool_queue (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [mbpq_pkg::OP_W-1:0]      op,
  input  logic [mbpq_pkg::IDX_W-1:0]     buf_index,
  // result channel
  output logic                           done,
  output logic [mbpq_pkg::STATUS_W-1:0]  status,
  output logic [mbpq_pkg::IDX_W-1:0]     out_index,
  output logic [mbpq_pkg::CNT_W-1:0]     ready_count,
  output logic [mbpq_pkg::CNT_W-1:0]     free_count,
  output logic [mbpq_pkg::CNT_W-1:0]     held_count,
  output logic [mbpq_pkg::CNT_W-1:0]     pool_count,
  output logic [mbpq_pkg::CNT_W-1:0]     max_ready,
  output logic [mbpq_pkg::STAT_W-1:0]    sends_total,
  output logic [mbpq_pkg::STAT_W-1:0]    recvs_total,
  output logic [mbpq_pkg::STAT_W-1:0]    waits_total,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbpq_pkg::ADDR_W-1:0]    paddr,
  input  logic [mbpq_pkg::DATA_W-1:0]    pwdata,
  output logic [mbpq_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam logic [mbpq_pkg::CNT_W-1:0]  CNT_ONE  = mbpq_pkg::CNT_W'(1);
  localparam logic [mbpq_pkg::STAT_W-1:0] STAT_ONE = mbpq_pkg::STAT_W'(1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_LINK  = 4'b0100,
    S_PURGE = 4'b1000
  } state_t;

  state_t state, state_next;

  mbpq_pkg::cfg_t   cfg;
  mbpq_pkg::entry_t rd_entry;
  mbpq_pkg::entry_t wr_entry;

  logic [mbpq_pkg::OP_W-1:0]     op_q;
  logic [mbpq_pkg::IDX_W-1:0]    idx_q;

  logic [mbpq_pkg::IDX_W-1:0]    free_head, free_head_next;
  logic [mbpq_pkg::IDX_W-1:0]    ready_head, ready_head_next;
  logic [mbpq_pkg::IDX_W-1:0]    ready_tail, ready_tail_next;
  logic [mbpq_pkg::CNT_W-1:0]    ready_level, ready_level_next;
  logic [mbpq_pkg::CNT_W-1:0]    free_level, free_level_next;
  logic [mbpq_pkg::CNT_W-1:0]    held_level, held_level_next;
  logic [mbpq_pkg::CNT_W-1:0]    pool_level, pool_level_next;
  logic [mbpq_pkg::CNT_W-1:0]    peak_ready, peak_ready_next;
  logic [mbpq_pkg::STAT_W-1:0]   send_cnt, send_cnt_next;
  logic [mbpq_pkg::STAT_W-1:0]   recv_cnt, recv_cnt_next;
  logic [mbpq_pkg::STAT_W-1:0]   wait_cnt, wait_cnt_next;

  logic [mbpq_pkg::STATUS_W-1:0] status_q, res_status;
  logic [mbpq_pkg::IDX_W-1:0]    out_index_q, res_index;

  logic                          rd_en, wr_en, finish, purge_step;
  logic [mbpq_pkg::IDX_W-1:0]    rd_addr, wr_addr;

  logic [mbpq_pkg::CNT_W-1:0]    grow_half, grow_room, grow_n, grow_top;
  logic [mbpq_pkg::CNT_W-1:0]    ready_inc;
  logic                          held_ok;
  logic [mbpq_pkg::CNT_W-1:0]    init_n;

  mbpq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbpq_store u_store (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg.reinit),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry),
    .pool_level (pool_level),
    .rd_entry   (rd_entry)
  );

  // growth size: half the pool, capped at the room left in the store
  assign grow_half = mbpq_pkg::CNT_W'(pool_level / mbpq_pkg::GROWTH_DIVISOR);
  assign grow_room = mbpq_pkg::CNT_W'(mbpq_pkg::NUM_BUFS) - pool_level;
  assign grow_n    = (grow_half > grow_room) ? grow_room : grow_half;
  assign grow_top  = pool_level + grow_n - CNT_ONE;

  assign ready_inc = ready_level + CNT_ONE;
  assign held_ok   = (rd_entry.mark == mbpq_pkg::MARK_HELD) && (held_level != '0);

  // sequencer and next state of the list registers
  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    ready_head_next  = ready_head;
    ready_tail_next  = ready_tail;
    ready_level_next = ready_level;
    free_level_next  = free_level;
    held_level_next  = held_level;
    pool_level_next  = pool_level;
    peak_ready_next  = peak_ready;
    send_cnt_next    = send_cnt;
    recv_cnt_next    = recv_cnt;
    wait_cnt_next    = wait_cnt;
    rd_en            = 1'b0;
    rd_addr          = ready_head;
    wr_en            = 1'b0;
    wr_addr          = idx_q;
    wr_entry.mark    = mbpq_pkg::MARK_HELD;
    wr_entry.link    = '0;
    finish           = 1'b0;
    purge_step       = 1'b0;
    res_status       = mbpq_pkg::ST_OK;
    res_index        = '0;

    case (state)
      S_IDLE: begin
        // read the entry the command will touch
        if (start) begin
          rd_en      = 1'b1;
          state_next = S_EXEC;
          if (op inside {mbpq_pkg::OP_ALLOC, mbpq_pkg::OP_ALLOC_NW}) begin
            rd_addr = free_head;
          end else if (op inside {mbpq_pkg::OP_SEND, mbpq_pkg::OP_FREE}) begin
            rd_addr = buf_index;
          end
        end
      end

      S_EXEC: begin
        finish = 1'b1;
        case (op_q)
          mbpq_pkg::OP_ALLOC, mbpq_pkg::OP_ALLOC_NW: begin
            if (free_level != '0) begin
              // pop the free list head
              res_index       = free_head;
              free_head_next  = (free_level == CNT_ONE) ? '0 : rd_entry.link;
              free_level_next = free_level - CNT_ONE;
              held_level_next = held_level + CNT_ONE;
              wr_en           = 1'b1;
              wr_addr         = free_head;
            end else if (op_q == mbpq_pkg::OP_ALLOC && cfg.grow_en && grow_n != '0) begin
              // grow the pool and pop the top new entry
              res_index       = grow_top[mbpq_pkg::IDX_W-1:0];
              free_head_next  = (grow_n == CNT_ONE) ? '0
                                : grow_top[mbpq_pkg::IDX_W-1:0] - 1'b1;
              free_level_next = grow_n - CNT_ONE;
              pool_level_next = pool_level + grow_n;
              held_level_next = held_level + CNT_ONE;
              wr_en           = 1'b1;
              wr_addr         = grow_top[mbpq_pkg::IDX_W-1:0];
            end else begin
              res_status = mbpq_pkg::ST_NONE;
            end
          end

          mbpq_pkg::OP_SEND: begin
            if (held_ok) begin
              held_level_next  = held_level - CNT_ONE;
              ready_level_next = ready_inc;
              send_cnt_next    = send_cnt + STAT_ONE;
              peak_ready_next  = (ready_inc > peak_ready) ? ready_inc : peak_ready;
              ready_tail_next  = idx_q;
              wr_en            = 1'b1;
              wr_entry.mark    = mbpq_pkg::MARK_READY;
              if (ready_level == '0) begin
                ready_head_next = idx_q;
              end else begin
                // link the old tail first, mark the buffer next cycle
                wr_addr       = ready_tail;
                wr_entry.link = idx_q;
                finish        = 1'b0;
                state_next    = S_LINK;
              end
            end else begin
              res_status = mbpq_pkg::ST_NOT_HELD;
            end
          end

          mbpq_pkg::OP_RECV: begin
            if (ready_level == '0) begin
              res_status    = mbpq_pkg::ST_NONE;
              wait_cnt_next = wait_cnt + STAT_ONE;
            end else begin
              res_index        = ready_head;
              ready_level_next = ready_level - CNT_ONE;
              held_level_next  = held_level + CNT_ONE;
              recv_cnt_next    = recv_cnt + STAT_ONE;
              if (ready_level == CNT_ONE) begin
                ready_head_next = '0;
                ready_tail_next = '0;
              end else begin
                ready_head_next = rd_entry.link;
              end
              wr_en         = 1'b1;
              wr_addr       = ready_head;
              wr_entry.link = rd_entry.link;
            end
          end

          mbpq_pkg::OP_FREE: begin
            if (held_ok) begin
              wr_en           = 1'b1;
              wr_entry.mark   = mbpq_pkg::MARK_FREE;
              wr_entry.link   = (free_level == '0) ? '0 : free_head;
              free_head_next  = idx_q;
              free_level_next = free_level + CNT_ONE;
              held_level_next = held_level - CNT_ONE;
            end else begin
              res_status = mbpq_pkg::ST_NOT_HELD;
            end
          end

          mbpq_pkg::OP_PURGE: begin
            if (ready_level != '0) begin
              purge_step = 1'b1;
            end
          end

          default: begin
          end
        endcase
      end

      S_LINK: begin
        // mark the sent buffer as the new tail
        wr_en         = 1'b1;
        wr_entry.mark = mbpq_pkg::MARK_READY;
        finish        = 1'b1;
      end

      S_PURGE: begin
        purge_step = 1'b1;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // purge: move the ready head onto the free list, read the next one
    if (purge_step) begin
      finish           = 1'b0;
      ready_level_next = ready_level - CNT_ONE;
      recv_cnt_next    = recv_cnt + STAT_ONE;
      free_head_next   = ready_head;
      free_level_next  = free_level + CNT_ONE;
      wr_en            = 1'b1;
      wr_addr          = ready_head;
      wr_entry.mark    = mbpq_pkg::MARK_FREE;
      wr_entry.link    = (free_level == '0) ? '0 : free_head;
      if (ready_level == CNT_ONE) begin
        ready_head_next = '0;
        ready_tail_next = '0;
        finish          = 1'b1;
      end else begin
        ready_head_next = rd_entry.link;
        rd_en           = 1'b1;
        rd_addr         = rd_entry.link;
        state_next      = S_PURGE;
      end
    end

    if (finish) begin
      state_next = S_IDLE;
    end
  end

  // pool size used by reset and reinit
  assign init_n = rst ? mbpq_pkg::RESET_POOL_SIZE : cfg.init_n;

  // control and list registers
  always_ff @(posedge clk) begin
    if (rst || cfg.reinit) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      free_head   <= mbpq_pkg::IDX_W'(init_n - CNT_ONE);
      ready_head  <= '0;
      ready_tail  <= '0;
      ready_level <= '0;
      free_level  <= init_n;
      held_level  <= '0;
      pool_level  <= init_n;
      peak_ready  <= '0;
      send_cnt    <= '0;
      recv_cnt    <= '0;
      wait_cnt    <= '0;
    end else begin
      state       <= state_next;
      done        <= finish;
      free_head   <= free_head_next;
      ready_head  <= ready_head_next;
      ready_tail  <= ready_tail_next;
      ready_level <= ready_level_next;
      free_level  <= free_level_next;
      held_level  <= held_level_next;
      pool_level  <= pool_level_next;
      peak_ready  <= peak_ready_next;
      send_cnt    <= send_cnt_next;
      recv_cnt    <= recv_cnt_next;
      wait_cnt    <= wait_cnt_next;
    end
  end

  // command capture and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q  <= op;
      idx_q <= buf_index;
    end
    if (finish) begin
      status_q    <= res_status;
      out_index_q <= res_index;
    end
  end

  assign busy        = (state != S_IDLE);
  assign status      = status_q;
  assign out_index   = out_index_q;
  assign ready_count = ready_level;
  assign free_count  = free_level;
  assign held_count  = held_level;
  assign pool_count  = pool_level;
  assign max_ready   = peak_ready;
  assign sends_total = send_cnt;
  assign recvs_total = recv_cnt;
  assign waits_total = wait_cnt;

  // every buffer of the pool is in exactly one place
  `MBPQ_CHECK(a_levels_sum, (32'(ready_level) + 32'(free_level) + 32'(held_level) == 32'(pool_level)), "pool levels do not add up")
  // peak never falls below the current queue length
  `MBPQ_CHECK(a_peak_ready, (peak_ready >= ready_level), "peak ready below ready level")
  // a result strobe only while the sequencer is idle
  `MBPQ_CHECK_IMP(a_done_idle, done, !busy, "result strobe while busy")
  // list walk never reads the entry it is writing
  `MBPQ_CHECK_IMP(a_rd_wr_clash, (rd_en && wr_en), (rd_addr != wr_addr), "link memory read and write collide")

endmodule
